@@ rtl/lwce_pkg.sv @@
// Package for the LCD window command emitter.
// Types, opcodes and screen limits shared by all lwce modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lwce_pkg;

   // Screen size; pixel requests outside it are dropped.
   localparam logic [16:0] SCREEN_WIDTH  = 17'd240;
   localparam logic [16:0] SCREEN_HEIGHT = 17'd320;

   // Controller opcodes.
   localparam logic [7:0] OP_COL_SET   = 8'h2A;
   localparam logic [7:0] OP_ROW_SET   = 8'h2B;
   localparam logic [7:0] OP_RAM_WRITE = 8'h2C;

   // Cache value after reset.
   localparam logic [15:0] CACHE_RESET = 16'hFFFF;

   // Classified job, front to back.
   typedef struct packed {
      logic        col_send;
      logic        row_send;
      logic        pixel;
      logic [15:0] c0;
      logic [15:0] c1;
      logic [15:0] r0;
      logic [15:0] r1;
      logic [15:0] colour;
   } job_type;

   // One output byte.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_command;
      logic       last;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/lwce_front.sv @@
// Front end: accepts requests, computes window ends, checks the cache.
// Depends on lwce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lwce_front
   import lwce_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_mode,
   input  wire logic signed [16:0] req_col,
   input  wire logic signed [16:0] req_row,
   input  wire logic [15:0]        req_width,
   input  wire logic [15:0]        req_height,
   input  wire logic [15:0]        req_colour,
   input  wire logic               jq_full,
   output job_type                 jq_data,
   output logic                    jq_push
);

   logic [15:0] col_start_ff, col_end_ff, row_start_ff, row_end_ff;
   logic [15:0] col_start_in, col_end_in, row_start_in, row_end_in;
   logic [15:0] w_eff, h_eff, c0, r0, c1, r1;
   logic        off_screen, accept, col_send, row_send;

   always_comb begin
      c0    = req_col[15:0];
      r0    = req_row[15:0];
      w_eff = req_mode ? 16'd1 : req_width;
      h_eff = req_mode ? 16'd1 : req_height;
      c1    = c0 + (w_eff - 16'd1);
      r1    = r0 + (h_eff - 16'd1);
      // negative or beyond the panel edge
      off_screen = req_mode && (req_col[16] || req_row[16] ||
                   (unsigned'(req_col) >= SCREEN_WIDTH) ||
                   (unsigned'(req_row) >= SCREEN_HEIGHT));
      col_send = (c0 != col_start_ff) || (c1 != col_end_ff);
      row_send = (r0 != row_start_ff) || (r1 != row_end_ff);
      accept   = req_valid && !jq_full;
      jq_push  = accept && !off_screen;

      jq_data.col_send = col_send;
      jq_data.row_send = row_send;
      jq_data.pixel    = req_mode;
      jq_data.c0       = c0;
      jq_data.c1       = c1;
      jq_data.r0       = r0;
      jq_data.r1       = r1;
      jq_data.colour   = req_colour;

      col_start_in = col_start_ff;
      col_end_in   = col_end_ff;
      row_start_in = row_start_ff;
      row_end_in   = row_end_ff;
      if (jq_push) begin
         col_start_in = c0;
         col_end_in   = c1;
         row_start_in = r0;
         row_end_in   = r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_start_ff <= CACHE_RESET;
         col_end_ff   <= CACHE_RESET;
         row_start_ff <= CACHE_RESET;
         row_end_ff   <= CACHE_RESET;
      end else begin
         col_start_ff <= col_start_in;
         col_end_ff   <= col_end_in;
         row_start_ff <= row_start_in;
         row_end_ff   <= row_end_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lwce_job_q.sv @@
// Two-entry job queue between front and back.
// Depends on lwce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lwce_job_q
   import lwce_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type wr_data,
   input  wire logic    pop,
   output job_type      rd_data,
   output logic         full,
   output logic         empty
);

   job_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;

   always_comb begin
      full      = (cnt_ff == 2'd2);
      empty     = (cnt_ff == 2'd0);
      rd_data   = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_data;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lwce_back.sv @@
// Back end: walks each job byte by byte into a two-entry output queue.
// Depends on lwce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lwce_back
   import lwce_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire job_type jq_data,
   input  wire logic    jq_empty,
   output logic         jq_pop,
   output rsp_type      rsp,
   output logic         rsp_empty,
   input  wire logic    rsp_pop
);

   typedef enum logic [3:0] {
      COL_CMD, COL_SH, COL_SL, COL_EH, COL_EL,
      ROW_CMD, ROW_SH, ROW_SL, ROW_EH, ROW_EL,
      RAM_CMD, PIX_H, PIX_L
   } step_type;

   step_type    step_ff, step_in, step_next, step_first;
   job_type     job_ff, job_in;
   logic        busy_ff, busy_in;
   rsp_type     cur;
   logic        emit, done, load;

   rsp_type     oq_ff [2];
   logic        oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [1:0]  oq_cnt_ff, oq_cnt_in;
   logic        oq_full, oq_pop;

   always_comb begin
      unique case (step_ff)
         COL_CMD: cur = '{OP_COL_SET,       1'b1, 1'b0};
         COL_SH:  cur = '{job_ff.c0[15:8],  1'b0, 1'b0};
         COL_SL:  cur = '{job_ff.c0[7:0],   1'b0, 1'b0};
         COL_EH:  cur = '{job_ff.c1[15:8],  1'b0, 1'b0};
         COL_EL:  cur = '{job_ff.c1[7:0],   1'b0, 1'b0};
         ROW_CMD: cur = '{OP_ROW_SET,       1'b1, 1'b0};
         ROW_SH:  cur = '{job_ff.r0[15:8],  1'b0, 1'b0};
         ROW_SL:  cur = '{job_ff.r0[7:0],   1'b0, 1'b0};
         ROW_EH:  cur = '{job_ff.r1[15:8],  1'b0, 1'b0};
         ROW_EL:  cur = '{job_ff.r1[7:0],   1'b0, 1'b0};
         RAM_CMD: cur = '{OP_RAM_WRITE,     1'b1, !job_ff.pixel};
         PIX_H:   cur = '{job_ff.colour[15:8], 1'b0, 1'b0};
         PIX_L:   cur = '{job_ff.colour[7:0],  1'b0, 1'b1};
         default: cur = '{OP_RAM_WRITE,     1'b1, 1'b1};
      endcase

      unique case (step_ff)
         COL_CMD: step_next = COL_SH;
         COL_SH:  step_next = COL_SL;
         COL_SL:  step_next = COL_EH;
         COL_EH:  step_next = COL_EL;
         COL_EL:  step_next = job_ff.row_send ? ROW_CMD : RAM_CMD;
         ROW_CMD: step_next = ROW_SH;
         ROW_SH:  step_next = ROW_SL;
         ROW_SL:  step_next = ROW_EH;
         ROW_EH:  step_next = ROW_EL;
         ROW_EL:  step_next = RAM_CMD;
         RAM_CMD: step_next = PIX_H;
         PIX_H:   step_next = PIX_L;
         default: step_next = RAM_CMD;
      endcase

      step_first = jq_data.col_send ? COL_CMD :
                   jq_data.row_send ? ROW_CMD : RAM_CMD;

      oq_full = (oq_cnt_ff == 2'd2);
      emit    = busy_ff && !oq_full;
      done    = emit && cur.last;
      load    = !jq_empty && (!busy_ff || done);
      jq_pop  = load;

      busy_in = busy_ff;
      job_in  = job_ff;
      step_in = step_ff;
      if (load) begin
         busy_in = 1'b1;
         job_in  = jq_data;
         step_in = step_first;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (emit) begin
         step_in = step_next;
      end

      rsp_empty = (oq_cnt_ff == 2'd0);
      rsp       = oq_ff[oq_rd_ff];
      oq_pop    = rsp_pop && !rsp_empty;
      oq_wr_in  = oq_wr_ff ^ emit;
      oq_rd_in  = oq_rd_ff ^ oq_pop;
      oq_cnt_in = oq_cnt_ff + {1'b0, emit} - {1'b0, oq_pop};
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) oq_ff[oq_wr_ff] <= cur;
      if (reset) begin
         busy_ff   <= 1'b0;
         step_ff   <= RAM_CMD;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         busy_ff   <= busy_in;
         step_ff   <= step_in;
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lcd_window_command_emitter_top.sv @@
// Top level of the LCD window command emitter.
// Depends on lwce_pkg, lwce_front, lwce_job_q and lwce_back.
//
//   Channel   Handshake          Payload
//   request   push / full        req_mode, req_col, req_row, req_width,
//                                req_height, req_colour
//   response  empty / pop        rsp_out_byte, rsp_is_command, rsp_last
//
// Each request that is not dropped becomes 1 to 13 response bytes; the back
// end produces one byte per cycle while its output queue has room.
// Dropped off-screen pixels never reach the job queue or the back end.
// With the back end idle, the first byte of a request passes through the job
// queue, the back end's job register and the output queue to the response ports.
// Synchronous active-high reset empties both queues and sets the window
// cache to all ones. Either side may stall freely; the job queue lets the
// front keep taking requests while the back waits on pop.
`timescale 1ns / 1ps
`default_nettype none
module lcd_window_command_emitter_top
   import lwce_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request side
   input  wire logic               push,
   output logic                    full,
   input  wire logic               req_mode,
   input  wire logic signed [16:0] req_col,
   input  wire logic signed [16:0] req_row,
   input  wire logic [15:0]        req_width,
   input  wire logic [15:0]        req_height,
   input  wire logic [15:0]        req_colour,
   // response side
   output logic                    empty,
   input  wire logic               pop,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_is_command,
   output logic                    rsp_last
);

   job_type  jq_wr_data, jq_rd_data;
   logic     jq_push, jq_pop, jq_full, jq_empty;
   rsp_type  rsp;

   // Front: window math and cache compare happen in the transfer cycle,
   // so the cache always reflects every request already passed to the job queue.
   lwce_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (push),
      .req_mode   (req_mode),
      .req_col    (req_col),
      .req_row    (req_row),
      .req_width  (req_width),
      .req_height (req_height),
      .req_colour (req_colour),
      .jq_full    (jq_full),
      .jq_data    (jq_wr_data),
      .jq_push    (jq_push)
   );

   lwce_job_q u_job_q (
      .clock   (clock),
      .reset   (reset),
      .push    (jq_push),
      .wr_data (jq_wr_data),
      .pop     (jq_pop),
      .rd_data (jq_rd_data),
      .full    (jq_full),
      .empty   (jq_empty)
   );

   // Back: byte sequencer plus output queue.
   lwce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .jq_data   (jq_rd_data),
      .jq_empty  (jq_empty),
      .jq_pop    (jq_pop),
      .rsp       (rsp),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   assign full           = jq_full;
   assign rsp_out_byte   = rsp.out_byte;
   assign rsp_is_command = rsp.is_command;
   assign rsp_last       = rsp.last;

endmodule
`default_nettype wire

@@ rtl/lwce_checker.sv @@
// Port-level checks for the LCD window command emitter, bound to the top.
// Depends on lwce_pkg and lcd_window_command_emitter_top.
`timescale 1ns / 1ps
`default_nettype none
module lwce_checker
   import lwce_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               full,
   input  wire logic               empty,
   input  wire logic               pop,
   input  wire logic [7:0]         rsp_out_byte,
   input  wire logic               rsp_is_command,
   input  wire logic               rsp_last
);

   // reset leaves both queues empty
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   // a waiting byte holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_out_byte) &&
      $stable(rsp_is_command) && $stable(rsp_last))
      else $error("response changed while stalled");

   // only the three opcodes go out as commands
   a_cmd_code: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_is_command |->
      (rsp_out_byte == OP_COL_SET) || (rsp_out_byte == OP_ROW_SET) ||
      (rsp_out_byte == OP_RAM_WRITE))
      else $error("unknown command byte");

   // a command can close an item only as RAM write
   a_last_cmd: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_last && rsp_is_command |-> rsp_out_byte == OP_RAM_WRITE)
      else $error("item closed by wrong command");

   // a set command never closes an item
   a_set_not_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_is_command && rsp_out_byte != OP_RAM_WRITE |-> !rsp_last)
      else $error("set command marked last");

endmodule

bind lcd_window_command_emitter_top lwce_checker u_lwce_checker (
   .clock          (clock),
   .reset          (reset),
   .full           (full),
   .empty          (empty),
   .pop            (pop),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_is_command (rsp_is_command),
   .rsp_last       (rsp_last)
);
`default_nettype wire

@@ dv/tb_lcd_window_command_emitter_top.sv @@
// Testbench for lcd_window_command_emitter_top: window and pixel requests in, display bytes out.
// Depends on lwce_pkg and the emitter RTL; a built-in predictor with its own window cache
// checks every byte transfer in order.
`timescale 1ns / 1ps
module tb_lcd_window_command_emitter_top;
   import lwce_pkg::*;

   // Request modes.
   localparam logic MODE_WINDOW = 1'b0;
   localparam logic MODE_PIXEL  = 1'b1;

   // Total number of requests in the random part, dropped pixels included.
   localparam int RANDOM_REQS = 412;
   // Receiver hold-off that fills the block and pushes back on the request side.
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_AFTER  = 150;

   // One pending request. drain_first keeps it back until every byte that is
   // still expected has come out.
   typedef struct {
      logic               mode;
      logic signed [16:0] col;
      logic signed [16:0] row;
      logic [15:0]        width;
      logic [15:0]        height;
      logic [15:0]        colour;
      logic               drain_first;
   } draw_req_type;

   // Receiver stall styles; each runs for a random stretch.
   typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_CADENCE} pop_style_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic               req_mode = 1'b0;
   logic signed [16:0] req_col = '0;
   logic signed [16:0] req_row = '0;
   logic [15:0]        req_width = '0;
   logic [15:0]        req_height = '0;
   logic [15:0]        req_colour = '0;
   logic               empty;
   logic               pop = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic               rsp_is_command;
   logic               rsp_last;

   draw_req_type pending_q[$];   // requests not yet transferred
   rsp_type      byte_q[$];      // bytes predicted but not yet popped

   // Predictor's copy of the window cache; all ones out of reset.
   logic [15:0] win_col_first = CACHE_RESET;
   logic [15:0] win_col_last  = CACHE_RESET;
   logic [15:0] win_row_first = CACHE_RESET;
   logic [15:0] win_row_last  = CACHE_RESET;

   int n_errors = 0;
   int n_taken  = 0;          // request transfers so far
   logic took_req = 1'b0;     // request transferred at the last rising edge

   lcd_window_command_emitter_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_mode       (req_mode),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_width      (req_width),
      .req_height     (req_height),
      .req_colour     (req_colour),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_command (rsp_is_command),
      .rsp_last       (rsp_last)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Pixel mode reads col/row as signed; anything off the panel is dropped.
   function automatic bit on_screen(draw_req_type r);
      int x;
      int y;
      x = int'(r.col);
      y = int'(r.row);
      return x >= 0 && x < int'(SCREEN_WIDTH) && y >= 0 && y < int'(SCREEN_HEIGHT);
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic cmd);
      byte_q.push_back('{out_byte: b, is_command: cmd, last: 1'b0});
   endtask

   // Opcode then start and end, big-endian.
   task automatic push_pair(input logic [7:0] op, input logic [15:0] first,
                            input logic [15:0] final_pos);
      push_byte(op, 1'b1);
      push_byte(first[15:8], 1'b0);
      push_byte(first[7:0], 1'b0);
      push_byte(final_pos[15:8], 1'b0);
      push_byte(final_pos[7:0], 1'b0);
   endtask

   // End = start + size - 1, wrapping at 16 bits. A pair goes out only when it
   // differs from the cached pair; the RAM-write opcode always goes out.
   task automatic open_window(input logic [15:0] c0, input logic [15:0] r0,
                              input logic [15:0] w, input logic [15:0] h);
      logic [15:0] c1;
      logic [15:0] r1;
      c1 = c0 + w - 16'd1;
      r1 = r0 + h - 16'd1;
      if (c0 != win_col_first || c1 != win_col_last) begin
         push_pair(OP_COL_SET, c0, c1);
         win_col_first = c0;
         win_col_last  = c1;
      end
      if (r0 != win_row_first || r1 != win_row_last) begin
         push_pair(OP_ROW_SET, r0, r1);
         win_row_first = r0;
         win_row_last  = r1;
      end
      push_byte(OP_RAM_WRITE, 1'b1);
   endtask

   // Expected bytes for one transferred request; last goes on the final one.
   task automatic predict_bytes(input draw_req_type r);
      if (r.mode == MODE_PIXEL) begin
         if (!on_screen(r)) return;
         open_window(r.col[15:0], r.row[15:0], 16'd1, 16'd1);
         push_byte(r.colour[15:8], 1'b0);
         push_byte(r.colour[7:0], 1'b0);
      end else begin
         // Window mode only looks at the low 16 bits of the start.
         open_window(r.col[15:0], r.row[15:0], r.width, r.height);
      end
      byte_q[byte_q.size() - 1].last = 1'b1;
   endtask

   task automatic add_req(input logic mode, input logic [16:0] col, input logic [16:0] row,
                          input logic [15:0] w, input logic [15:0] h,
                          input logic [15:0] colour, input logic drain_first);
      pending_q.push_back('{mode: mode, col: col, row: row, width: w, height: h,
                            colour: colour, drain_first: drain_first});
   endtask

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps.
   // Inputs change on the falling edge; transfers are seen on the rising edge.
   // ---------------------------------------------------------------------
   int burst_left = 8;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (!reset && push && !full) begin
         predict_bytes(pending_q[0]);
         void'(pending_q.pop_front());
         n_taken  <= n_taken + 1;
         took_req <= 1'b1;
      end else begin
         took_req <= 1'b0;
      end
   end

   always @(negedge clock) begin
      logic offer;
      offer = 1'b0;
      if (!reset) begin
         if (push && !took_req) begin
            // still waiting on full; keep the same request up
            offer = 1'b1;
         end else begin
            if (took_req) begin
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  case ($urandom_range(0, 9))
                     0, 1, 2: gap_left = 0;
                     3:       gap_left = $urandom_range(20, 40);
                     default: gap_left = $urandom_range(1, 12);
                  endcase
               end
            end
            if (gap_left > 0)
               gap_left = gap_left - 1;
            else if (pending_q.size() != 0)
               // a drain-first request waits until the block has gone quiet
               offer = !(pending_q[0].drain_first && byte_q.size() != 0);
         end
      end
      push <= offer;
      if (offer) begin
         req_mode   <= pending_q[0].mode;
         req_col    <= pending_q[0].col;
         req_row    <= pending_q[0].row;
         req_width  <= pending_q[0].width;
         req_height <= pending_q[0].height;
         req_colour <= pending_q[0].colour;
      end else begin
         // junk on the payload while push is low
         req_mode   <= 1'($urandom_range(0, 1));
         req_col    <= 17'($urandom);
         req_row    <= 17'($urandom);
         req_width  <= 16'($urandom);
         req_height <= 16'($urandom);
         req_colour <= 16'($urandom);
      end
   end

   // ---------------------------------------------------------------------
   // Result side: pop follows its own stall styles, plus one long hold-off
   // once enough requests have gone in, so the block backs up into full.
   // ---------------------------------------------------------------------
   pop_style_type pop_style = POP_ALWAYS;
   int            style_left = 0;
   int            hold_left = 0;
   bit            long_hold_done = 1'b0;
   logic [1:0]    pop_phase = '0;

   always @(negedge clock) begin
      logic p;
      p = 1'b0;
      if (!reset) begin
         if (!long_hold_done && n_taken >= LONG_HOLD_AFTER) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
         end else begin
            if (style_left == 0) begin
               pop_style  = pop_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(16, 96);
            end
            style_left = style_left - 1;
            case (pop_style)
               POP_ALWAYS: p = 1'b1;
               POP_HALF:   p = 1'($urandom_range(0, 1));
               POP_SPARSE: p = ($urandom_range(0, 3) == 0);
               default:    p = (pop_phase != 2'b11);
            endcase
         end
         pop_phase <= pop_phase + 2'd1;
      end
      pop <= p;
   end

   // Byte monitor: each popped byte against the oldest expected one.
   always @(posedge clock) begin
      rsp_type exp_byte;
      if (!reset && pop && !empty) begin
         if (byte_q.size() == 0) begin
            $error("unexpected byte transfer: out_byte %0h is_command %0b last %0b",
                   rsp_out_byte, rsp_is_command, rsp_last);
            n_errors++;
         end else begin
            exp_byte = byte_q.pop_front();
            if (rsp_out_byte !== exp_byte.out_byte) begin
               $error("out_byte: expected %0h, got %0h", exp_byte.out_byte, rsp_out_byte);
               n_errors++;
            end
            if (rsp_is_command !== exp_byte.is_command) begin
               $error("is_command: expected %0b, got %0b", exp_byte.is_command,
                      rsp_is_command);
               n_errors++;
            end
            if (rsp_last !== exp_byte.last) begin
               $error("last: expected %0b, got %0b", exp_byte.last, rsp_last);
               n_errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      draw_req_type       r;
      int                 n_live;
      int                 n_rand;
      int                 kind;
      logic signed [16:0] pix_col;
      logic signed [16:0] pix_row;
      logic [16:0]        win_col;
      logic [16:0]        win_row;
      logic [15:0]        win_w;
      logic [15:0]        win_h;

      // Directed part.
      // window equal to the reset cache: RAM-write only
      add_req(MODE_WINDOW, 17'h0FFFF, 17'h0FFFF, 16'd1, 16'd1, 16'h0000, 1'b0);
      // both pairs change, then the same window again
      add_req(MODE_WINDOW, 17'h00000, 17'h00000, 16'd1, 16'd1, 16'hFFFF, 1'b0);
      add_req(MODE_WINDOW, 17'h00000, 17'h00000, 16'd1, 16'd1, 16'h0000, 1'b0);
      // zero width and height: end is start - 1 wrapped
      add_req(MODE_WINDOW, 17'h00000, 17'h00000, 16'd0, 16'd0, 16'h0000, 1'b0);
      // start beyond 16 bits, largest sizes
      add_req(MODE_WINDOW, 17'h1FFFF, 17'h10000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
      // column pair cached, row pair new
      add_req(MODE_WINDOW, 17'h1FFFF, 17'h00005, 16'hFFFF, 16'd3, 16'h0000, 1'b0);
      // on-screen pixels at the corners, then a repeat with the cache hit
      add_req(MODE_PIXEL, 17'd0, 17'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      add_req(MODE_PIXEL, 17'd239, 17'd319, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      add_req(MODE_PIXEL, 17'd239, 17'd319, 16'h5A5A, 16'hA5A5, 16'hA55A, 1'b0);
      // off-screen pixels on every edge and at the field extremes
      add_req(MODE_PIXEL, 17'd240, 17'd0, 16'd1, 16'd1, 16'h1234, 1'b0);
      add_req(MODE_PIXEL, 17'h1FFFF, 17'd0, 16'd1, 16'd1, 16'h1234, 1'b0);
      add_req(MODE_PIXEL, 17'd0, 17'd320, 16'd1, 16'd1, 16'h1234, 1'b0);
      add_req(MODE_PIXEL, 17'd0, 17'h1FFFF, 16'd1, 16'd1, 16'h1234, 1'b0);
      add_req(MODE_PIXEL, 17'h10000, 17'h10000, 16'd1, 16'd1, 16'h1234, 1'b0);
      add_req(MODE_PIXEL, 17'h0FFFF, 17'h0FFFF, 16'd1, 16'd1, 16'h1234, 1'b0);
      // sender waits for the block to drain before this one
      add_req(MODE_PIXEL, 17'd100, 17'd200, 16'd0, 16'd0, 16'h1234, 1'b1);
      // window equal to the pixel's 1x1 window: RAM-write only
      add_req(MODE_WINDOW, 17'd100, 17'd200, 16'd1, 16'd1, 16'h0000, 1'b0);
      add_req(MODE_WINDOW, 17'h0FFFF, 17'd0, 16'd1, 16'd0, 16'h0000, 1'b0);

      // Random part: mostly live requests, a share of dropped pixels, and
      // repeats that hit the window cache.
      n_live  = 0;
      n_rand  = 0;
      pix_col = 17'd0;
      pix_row = 17'd0;
      win_col = '0;
      win_row = '0;
      win_w   = 16'd1;
      win_h   = 16'd1;
      while (n_rand < RANDOM_REQS) begin
         kind = $urandom_range(0, 99);
         r.width  = 16'($urandom);
         r.height = 16'($urandom);
         r.colour = 16'($urandom);
         if (kind < 35) begin
            r.mode = MODE_PIXEL;
            if ($urandom_range(0, 3) != 0) begin
               pix_col = 17'($urandom_range(0, int'(SCREEN_WIDTH) - 1));
               pix_row = 17'($urandom_range(0, int'(SCREEN_HEIGHT) - 1));
            end
            r.col = pix_col;
            r.row = pix_row;
         end else if (kind < 45) begin
            r.mode = MODE_PIXEL;
            r.col  = 17'($urandom);
            r.row  = 17'($urandom);
         end else begin
            r.mode = MODE_WINDOW;
            if (kind < 75) begin
               win_col = 17'($urandom);
               win_row = 17'($urandom);
               win_w   = 16'($urandom);
               win_h   = 16'($urandom);
               // sizes at the edges now and then
               case ($urandom_range(0, 5))
                  0: win_w = 16'd0;
                  1: win_h = 16'd1;
                  2: win_w = 16'hFFFF;
                  3: win_h = 16'd0;
                  default: ;
               endcase
            end else begin
               // keep one or both pairs so the cache can hit
               case ($urandom_range(0, 2))
                  0: begin
                     win_row = 17'($urandom);
                     win_h   = 16'($urandom);
                  end
                  1: begin
                     win_col = 17'($urandom);
                     win_w   = 16'($urandom);
                  end
                  default: ;
               endcase
            end
            r.col    = win_col;
            r.row    = win_row;
            r.width  = win_w;
            r.height = win_h;
         end
         r.drain_first = (n_live == 60 || n_live == 200 || n_live == 330);
         if (r.mode == MODE_WINDOW || on_screen(r))
            n_live++;
         n_rand++;
         pending_q.push_back(r);
      end

      // Hold reset, then release it on a falling edge.
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Everything transferred and every byte back, then a short quiet spell
      // so a stray extra byte still gets caught.
      while (pending_q.size() != 0 || byte_q.size() != 0)
         @(posedge clock);
      repeat (32) @(posedge clock);
      if (n_errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog. Slowest correct run is roughly 430 requests, each with 13 bytes
   // at the sparsest pop rate and the longest request gap, plus the long hold-off:
   // some 320 us. Allow several times that.
   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
